FILE: rtl/core/sscw_pkg.sv
// shared types, constants and lookup tables of the seven-segment character writer
package sscw_pkg;

  localparam int unsigned SEG_COUNT  = 7;
  localparam int unsigned DIGIT_LAST = 5;

  localparam logic [7:0] CODE_CR    = 8'd13;
  localparam logic [7:0] CODE_FF    = 8'd12;
  localparam logic [7:0] CODE_SPACE = 8'd32;
  localparam logic [7:0] CODE_C     = 8'd67;

  localparam logic [7:0] PAT_C     = 8'h9c;
  localparam logic [7:0] PAT_BLANK = 8'h00;

  localparam logic [7:0] INTENSITY_RST = 8'hff;

  localparam logic [2:0] SEG_IDX_LAST = 3'(SEG_COUNT - 1);
  localparam logic [2:0] POS_LAST     = 3'(DIGIT_LAST);

  // segments a..g taken from bit 7 down to bit 1
  localparam logic [7:0] PATTERN_ROM [16] = '{
    8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0,
    8'hfe, 8'hf6, 8'h9c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // frame store byte address per digit position and segment
  localparam logic [5:0] ADDR_MAP [6][7] = '{
    '{6'd3,  6'd0,  6'd39, 6'd36, 6'd33, 6'd9,  6'd12},
    '{6'd21, 6'd18, 6'd15, 6'd27, 6'd30, 6'd6,  6'd45},
    '{6'd4,  6'd1,  6'd40, 6'd37, 6'd34, 6'd10, 6'd13},
    '{6'd22, 6'd19, 6'd16, 6'd28, 6'd31, 6'd7,  6'd46},
    '{6'd5,  6'd2,  6'd41, 6'd38, 6'd35, 6'd11, 6'd14},
    '{6'd23, 6'd20, 6'd17, 6'd29, 6'd32, 6'd8,  6'd47}
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEG,
    ST_CLR
  } emit_state_t;

  // job handed from the front end to the segment emitter
  typedef struct packed {
    logic       clr;
    logic [7:0] pattern;
    logic [2:0] pos;
  } emit_cmd_t;

  function automatic logic [7:0] pattern_lookup(input logic [7:0] code);
    logic [7:0] pat;
    priority if (code == CODE_C) begin
      pat = PAT_C;
    end else if (code == CODE_SPACE) begin
      pat = PAT_BLANK;
    end else begin
      pat = PATTERN_ROM[code[3:0]];
    end
    return pat;
  endfunction

endpackage

FILE: rtl/core/seven_segment_char_writer.sv
// top level of the seven-segment character writer
//
// channel | direction | beat fields
// --------+-----------+--------------------------------------------------
// in_     | input     | char_code
// out_    | output    | seg_address, seg_value, clear_all, last
// cfg_    | input     | data (intensity)
//
// a digit or letter is first accepted, then gives seven write beats
// from the shared segment shift unit, one per cycle while out_ready is high
// form feed is first accepted, then gives one clear beat; carriage return gives no beat
// out_ready low holds the current beat; in_ready stays low until the last beat
// synchronous active-low reset: cursor 0, intensity 255, emitter idle
module seven_segment_char_writer
  import sscw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_seg_address,
  output logic [7:0] out_seg_value,
  output logic       out_clear_all,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] intensity_r, intensity_nxt;
  logic [2:0] cursor_r, cursor_nxt;
  logic       busy;
  logic       in_beat;
  logic       cmd_valid;
  emit_cmd_t  cmd;

  // config is always taken; the user must send it only while the block is idle, the block itself does not enforce this
  assign cfg_ready = 1'b1;

  // a new character is taken only once the emitter has drained
  assign in_ready = !busy;
  assign in_beat  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intensity_r <= INTENSITY_RST;
      cursor_r    <= '0;
    end else begin
      intensity_r <= intensity_nxt;
      cursor_r    <= cursor_nxt;
    end
  end

  always_comb begin
    intensity_nxt = intensity_r;
    if (cfg_valid) begin
      intensity_nxt = cfg_data;
    end
  end

  // cursor: return and form feed home it, everything else advances and
  // sticks at the last digit so later characters overwrite it
  always_comb begin
    cursor_nxt = cursor_r;
    if (in_beat) begin
      priority if ((in_char_code == CODE_CR) || (in_char_code == CODE_FF)) begin
        cursor_nxt = '0;
      end else if (cursor_r == POS_LAST) begin
        cursor_nxt = POS_LAST;
      end else begin
        cursor_nxt = cursor_r + 3'd1;
      end
    end
  end

  // carriage return starts no job; form feed starts a single clear beat
  assign cmd_valid   = in_beat && (in_char_code != CODE_CR);
  assign cmd.clr     = (in_char_code == CODE_FF);
  assign cmd.pattern = pattern_lookup(in_char_code);
  assign cmd.pos     = cursor_r;

  sscw_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .intensity       (intensity_r),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seg_address (out_seg_address),
    .out_seg_value   (out_seg_value),
    .out_clear_all   (out_clear_all),
    .out_last        (out_last)
  );

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= POS_LAST)
    else $error("cursor beyond last digit");

  a_cr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_char_code == CODE_CR)) |=> (!out_valid && (cursor_r == '0)))
    else $error("carriage return produced a beat or kept the cursor");

  a_ff_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_char_code == CODE_FF)) |=> (out_valid && out_clear_all && out_last))
    else $error("form feed did not produce a clear beat");

endmodule

FILE: rtl/core/sscw_emit.sv
// segment emitter: shifts one pattern out as seven frame-store write beats, or gives one clear beat for a clear job
module sscw_emit
  import sscw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  emit_cmd_t  cmd,
  input  logic [7:0] intensity,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_seg_address,
  output logic [7:0] out_seg_value,
  output logic       out_clear_all,
  output logic       out_last
);

  emit_state_t state_r, state_nxt;
  logic [7:0]  pattern_r, pattern_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        beat;

  assign beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pattern_r <= pattern_nxt;
    pos_r     <= pos_nxt;
    idx_r     <= idx_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    pattern_nxt = pattern_r;
    pos_nxt     = pos_r;
    idx_nxt     = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          pattern_nxt = cmd.pattern;
          pos_nxt     = cmd.pos;
          idx_nxt     = '0;
          state_nxt   = cmd.clr ? ST_CLR : ST_SEG;
        end
      end
      ST_SEG: begin
        if (beat) begin
          pattern_nxt = {pattern_r[6:0], 1'b0};
          idx_nxt     = idx_r + 3'd1;
          if (idx_r == SEG_IDX_LAST) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_CLR: begin
        if (beat) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = busy;
  assign out_seg_address = (state_r == ST_SEG) ? ADDR_MAP[pos_r][idx_r] : '0;
  assign out_seg_value   = ((state_r == ST_SEG) && pattern_r[7]) ? intensity : '0;
  assign out_clear_all   = (state_r == ST_CLR);
  assign out_last        = (state_r == ST_CLR) ||
                           ((state_r == ST_SEG) && (idx_r == SEG_IDX_LAST));

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEG) |-> (pos_r <= POS_LAST))
    else $error("digit position out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && out_last) |=> !busy)
    else $error("emitter still busy after final beat");

  a_seg_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && (state_r == ST_SEG) && !out_last) |=> (busy && (idx_r == $past(idx_r) + 3'd1)))
    else $error("segment index did not advance on a beat");

endmodule
